// ----- rtl/core/antc_pkg.sv -----
`default_nettype none

package antc_pkg;

	localparam int SET_W         = 4;
	localparam int COORD_W       = 8;
	localparam int DIM_W         = 9;
	localparam int ATLAS_W       = 8;
	localparam int ROM_POS_W     = 3;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 9;
	localparam int PATTERN_COUNT = 47;
	localparam int WINDOW_CELLS  = 9;

	localparam logic [DIM_W-1:0]   MAP_DIM    = 9'd256;
	localparam logic [SET_W-1:0]   AUTO_LIMIT = 4'd4;
	localparam logic [ATLAS_W-1:0] MISS_COL   = 8'd7;
	localparam logic [ATLAS_W-1:0] MISS_ROW   = 8'd5;

	// per-cell pattern code
	localparam logic [1:0] T_NO  = 2'd0;
	localparam logic [1:0] T_YES = 2'd1;
	localparam logic [1:0] T_ANY = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_WIDTH  = 2'd0,
		REG_MAP_HEIGHT = 2'd1,
		REG_MANUAL_COL = 2'd2,
		REG_MANUAL_ROW = 2'd3
	} antc_reg_t;

	// cells[0] is top-left, cells[8] is bottom-right
	typedef struct packed {
		logic [ROM_POS_W-1:0]         col;
		logic [ROM_POS_W-1:0]         row;
		logic [0:WINDOW_CELLS-1][1:0] cells;
	} antc_pat_t;

	localparam antc_pat_t PAT_ROM [PATTERN_COUNT] = '{
		'{3'd0, 3'd0, {2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1}},
		'{3'd1, 3'd0, {2'd2, 2'd0, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1}},
		'{3'd2, 3'd0, {2'd2, 2'd0, 2'd2, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd2}},
		'{3'd3, 3'd0, {2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd2}},
		'{3'd4, 3'd0, {2'd2, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd0}},
		'{3'd5, 3'd0, {2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd2}},
		'{3'd6, 3'd0, {2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0}},
		'{3'd7, 3'd0, {2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1}},
		'{3'd0, 3'd1, {2'd2, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1}},
		'{3'd1, 3'd1, {2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1}},
		'{3'd2, 3'd1, {2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd2}},
		'{3'd3, 3'd1, {2'd2, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd2}},
		'{3'd4, 3'd1, {2'd2, 2'd1, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd0}},
		'{3'd5, 3'd1, {2'd0, 2'd1, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd2}},
		'{3'd6, 3'd1, {2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1}},
		'{3'd7, 3'd1, {2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1}},
		'{3'd0, 3'd2, {2'd2, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 2'd2}},
		'{3'd1, 3'd2, {2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd0, 2'd2}},
		'{3'd2, 3'd2, {2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd0, 2'd2, 2'd0, 2'd2}},
		'{3'd3, 3'd2, {2'd2, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd2}},
		'{3'd4, 3'd2, {2'd2, 2'd1, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1}},
		'{3'd5, 3'd2, {2'd0, 2'd1, 2'd2, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd2}},
		'{3'd6, 3'd2, {2'd0, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1}},
		'{3'd7, 3'd2, {2'd0, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0}},
		'{3'd0, 3'd3, {2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 2'd2}},
		'{3'd1, 3'd3, {2'd2, 2'd0, 2'd2, 2'd1, 2'd1, 2'd1, 2'd2, 2'd0, 2'd2}},
		'{3'd2, 3'd3, {2'd2, 2'd0, 2'd2, 2'd1, 2'd1, 2'd0, 2'd2, 2'd0, 2'd2}},
		'{3'd3, 3'd3, {2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd2}},
		'{3'd4, 3'd3, {2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0}},
		'{3'd5, 3'd3, {2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1}},
		'{3'd6, 3'd3, {2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0}},
		'{3'd7, 3'd3, {2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0}},
		'{3'd0, 3'd4, {2'd2, 2'd0, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0}},
		'{3'd1, 3'd4, {2'd2, 2'd0, 2'd2, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0}},
		'{3'd2, 3'd4, {2'd2, 2'd0, 2'd2, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1}},
		'{3'd3, 3'd4, {2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0}},
		'{3'd4, 3'd4, {2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd0}},
		'{3'd5, 3'd4, {2'd2, 2'd0, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd2}},
		'{3'd6, 3'd4, {2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0}},
		'{3'd7, 3'd4, {2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1}},
		'{3'd0, 3'd5, {2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd0, 2'd2}},
		'{3'd1, 3'd5, {2'd0, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd0, 2'd2}},
		'{3'd2, 3'd5, {2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd0, 2'd2}},
		'{3'd3, 3'd5, {2'd0, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1}},
		'{3'd4, 3'd5, {2'd2, 2'd1, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 2'd2}},
		'{3'd5, 3'd5, {2'd0, 2'd1, 2'd2, 2'd1, 2'd1, 2'd0, 2'd2, 2'd0, 2'd2}},
		'{3'd6, 3'd5, {2'd0, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0}}
	};

	// mask bit i belongs to window cell i
	function automatic logic pattern_hits(antc_pat_t pat, logic [WINDOW_CELLS-1:0] mask);
		logic hit;
		hit = 1'b1;
		for (int i = 0; i < WINDOW_CELLS; i++) begin
			if (pat.cells[i] != T_ANY && pat.cells[i] != {1'b0, mask[i]}) begin
				hit = 1'b0;
			end
		end
		return hit;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/antc_window_lane.sv -----
`default_nettype none

module antc_window_lane (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [antc_pkg::SET_W-1:0] id,
	input  wire logic [antc_pkg::SET_W-1:0] target,
	input  wire logic                      on_map,
	output logic                           match_s1
);
	import antc_pkg::*;

	// off-map cells always count as matching
	always_ff @(posedge clk) begin
		if (en) begin
			match_s1 <= !on_map || (id == target);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/antc_pattern_bank.sv -----
`default_nettype none

module antc_pattern_bank (
	input  wire logic                                 clk,
	input  wire logic                                 en,
	input  wire logic [antc_pkg::WINDOW_CELLS-1:0]    mask_s1,
	output logic      [antc_pkg::PATTERN_COUNT-1:0]   hit_s2
);
	import antc_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < PATTERN_COUNT; p++) begin
				hit_s2[p] <= pattern_hits(PAT_ROM[p], mask_s1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/antc_merge.sv -----
`default_nettype none

module antc_merge (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic [antc_pkg::PATTERN_COUNT-1:0]  hit_s2,
	input  wire logic [antc_pkg::SET_W-1:0]          set_s2,
	input  wire logic [antc_pkg::ATLAS_W-1:0]        manual_col,
	input  wire logic [antc_pkg::ATLAS_W-1:0]        manual_row,
	output logic      [antc_pkg::SET_W-1:0]          out_set,
	output logic      [antc_pkg::ATLAS_W-1:0]        atlas_col,
	output logic      [antc_pkg::ATLAS_W-1:0]        atlas_row
);
	import antc_pkg::*;

	logic [ATLAS_W-1:0] col_d;
	logic [ATLAS_W-1:0] row_d;
	logic [SET_W-1:0]   set_s3;
	logic [ATLAS_W-1:0] col_s3;
	logic [ATLAS_W-1:0] row_s3;

	// first hit in rom order wins, so scan from the back
	always_comb begin
		col_d = MISS_COL;
		row_d = MISS_ROW;
		for (int p = PATTERN_COUNT - 1; p >= 0; p--) begin
			if (hit_s2[p]) begin
				col_d = ATLAS_W'(PAT_ROM[p].col);
				row_d = ATLAS_W'(PAT_ROM[p].row);
			end
		end
		if (set_s2 >= AUTO_LIMIT) begin
			col_d = manual_col;
			row_d = manual_row;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			set_s3 <= set_s2;
			col_s3 <= col_d;
			row_s3 <= row_d;
		end
	end

	assign out_set   = set_s3;
	assign atlas_col = col_s3;
	assign atlas_row = row_s3;

endmodule

`default_nettype wire

// ----- rtl/core/autotile_neighbour_classifier_top.sv -----
// registered stages in order: lane compare, pattern bank, merge, whose valid drives out_valid
// throughput: one item per cycle while out_ready is high; a stage advances when it is
// empty or the next one does, so the result register accepts a new item in the cycle
// the old one is taken
// reset (arst_n low, asynchronous): all stage valid bits clear, map size 256x256,
// manual selection column 0 row 0
`default_nettype none

module autotile_neighbour_classifier_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [antc_pkg::SET_W-1:0]           target_set,
	input  wire logic [antc_pkg::COORD_W-1:0]         cell_col,
	input  wire logic [antc_pkg::COORD_W-1:0]         cell_row,
	input  wire logic [antc_pkg::SET_W-1:0]           nb_top_left,
	input  wire logic [antc_pkg::SET_W-1:0]           nb_top,
	input  wire logic [antc_pkg::SET_W-1:0]           nb_top_right,
	input  wire logic [antc_pkg::SET_W-1:0]           nb_left,
	input  wire logic [antc_pkg::SET_W-1:0]           nb_centre,
	input  wire logic [antc_pkg::SET_W-1:0]           nb_right,
	input  wire logic [antc_pkg::SET_W-1:0]           nb_bottom_left,
	input  wire logic [antc_pkg::SET_W-1:0]           nb_bottom,
	input  wire logic [antc_pkg::SET_W-1:0]           nb_bottom_right,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic      [antc_pkg::SET_W-1:0]           out_set,
	output logic      [antc_pkg::ATLAS_W-1:0]         atlas_col,
	output logic      [antc_pkg::ATLAS_W-1:0]         atlas_row,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [antc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [antc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import antc_pkg::*;

	logic [DIM_W-1:0]   map_width_q;
	logic [DIM_W-1:0]   map_height_q;
	logic [ATLAS_W-1:0] manual_col_q;
	logic [ATLAS_W-1:0] manual_row_q;

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	logic top_on, bot_on, left_on, right_on;
	logic [WINDOW_CELLS-1:0] on_map;
	logic [SET_W-1:0]        nb_id [WINDOW_CELLS];
	logic [WINDOW_CELLS-1:0] mask_s1;
	logic [PATTERN_COUNT-1:0] hit_s2;
	logic [SET_W-1:0]        set_s1;
	logic [SET_W-1:0]        set_s2;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= MAP_DIM;
			map_height_q <= MAP_DIM;
			manual_col_q <= '0;
			manual_row_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAP_WIDTH:  map_width_q  <= cfg_data;
				REG_MAP_HEIGHT: map_height_q <= cfg_data;
				REG_MANUAL_COL: manual_col_q <= cfg_data[ATLAS_W-1:0];
				REG_MANUAL_ROW: manual_row_q <= cfg_data[ATLAS_W-1:0];
				default: ;
			endcase
		end
	end

	// stage advance: a stage moves when it is empty or the next one moves
	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// map edges
	assign top_on   = cell_row != '0;
	assign left_on  = cell_col != '0;
	assign bot_on   = ({1'b0, cell_row} + DIM_W'(1)) < map_height_q;
	assign right_on = ({1'b0, cell_col} + DIM_W'(1)) < map_width_q;

	assign on_map[0] = top_on && left_on;
	assign on_map[1] = top_on;
	assign on_map[2] = top_on && right_on;
	assign on_map[3] = left_on;
	assign on_map[4] = 1'b1;
	assign on_map[5] = right_on;
	assign on_map[6] = bot_on && left_on;
	assign on_map[7] = bot_on;
	assign on_map[8] = bot_on && right_on;

	assign nb_id[0] = nb_top_left;
	assign nb_id[1] = nb_top;
	assign nb_id[2] = nb_top_right;
	assign nb_id[3] = nb_left;
	assign nb_id[4] = nb_centre;
	assign nb_id[5] = nb_right;
	assign nb_id[6] = nb_bottom_left;
	assign nb_id[7] = nb_bottom;
	assign nb_id[8] = nb_bottom_right;

	for (genvar i = 0; i < WINDOW_CELLS; i++) begin : g_lane
		antc_window_lane u_lane (
			.clk      (clk),
			.en       (en1),
			.id       (nb_id[i]),
			.target   (target_set),
			.on_map   (on_map[i]),
			.match_s1 (mask_s1[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en1) set_s1 <= target_set;
		if (en2) set_s2 <= set_s1;
	end

	antc_pattern_bank u_bank (
		.clk     (clk),
		.en      (en2),
		.mask_s1 (mask_s1),
		.hit_s2  (hit_s2)
	);

	antc_merge u_merge (
		.clk        (clk),
		.en         (en3),
		.hit_s2     (hit_s2),
		.set_s2     (set_s2),
		.manual_col (manual_col_q),
		.manual_row (manual_row_q),
		.out_set    (out_set),
		.atlas_col  (atlas_col),
		.atlas_row  (atlas_row)
	);

`ifndef ASSERT_OFF
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted item did not enter the first stage");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input stalled with a free first stage");

	a_auto_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_set < AUTO_LIMIT) |-> (atlas_col < 8'd8 && atlas_row < 8'd6))
		else $error("autotiled result outside the atlas");

	a_stall_keeps_result: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !out_ready) |=> (v_s3 && $stable(atlas_col) && $stable(atlas_row)))
		else $error("stalled result lost or changed");
`endif

endmodule

`default_nettype wire
